// ----- rtl/rbpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbpm_pkg
// Shared types and constants of the ring buffer pool manager.
// ----------------------------------------------------------------------------
package rbpm_pkg;

  localparam int HANDLE_W = 8;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;
  localparam int OUTST_W  = 9;
  localparam int SHORT_W  = 32;

  localparam int DEF_POOL_BUFFERS = 256;
  localparam int MAX_BATCH        = 16;
  localparam int CNT_MAX          = (1 << CNT_W) - 1;
  localparam int BATCH_CAP        = (MAX_BATCH < CNT_MAX) ? MAX_BATCH : CNT_MAX;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OUTST_W-1:0] OUTSTANDING_MAX = '1;

  localparam logic OP_GET    = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_OCCUPIED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_GET      = 2'd0,
    KIND_GET_NONE = 2'd1,
    KIND_RETURN   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_INIT  = 2'd0,
    ST_IDLE  = 2'd1,
    ST_START = 2'd2,
    ST_GRANT = 2'd3
  } state_e;

  typedef struct packed {
    logic                opcode;
    logic [CNT_W-1:0]    request_count;
    logic [HANDLE_W-1:0] returned_handle;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted_handle;
    logic                handle_valid;
    logic                last;
    logic [OUTST_W-1:0]  outstanding;
    logic [SHORT_W-1:0]  shortage_count;
  } result_t;

  typedef struct packed {
    kind_e               kind;
    logic [CNT_W-1:0]    count;
    logic [HANDLE_W-1:0] handle;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// ----- rtl/rbpm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbpm_front
// Takes request transactions, classifies them and pushes jobs to the queue.
// ----------------------------------------------------------------------------
module rbpm_front (
  input  wire logic                  start,
  output logic                       busy,
  input  wire rbpm_pkg::cmd_t        cmd_i,
  input  wire rbpm_pkg::queue_stat_t q_stat_i,
  input  wire logic                  pool_ready_i,
  output logic                       push_o,
  output rbpm_pkg::job_t             job_o
);

  localparam int CntW = rbpm_pkg::CNT_W;

  logic [CntW-1:0] count_sat;

  assign busy   = q_stat_i.full || !pool_ready_i;
  assign push_o = start && !busy;

  // batch size is capped before it reaches the back end
  assign count_sat = (32'(cmd_i.request_count) > 32'(rbpm_pkg::BATCH_CAP)) ?
                     CntW'(rbpm_pkg::BATCH_CAP) : cmd_i.request_count;

  always_comb begin
    job_o.count  = count_sat;
    job_o.handle = cmd_i.returned_handle;
    if (cmd_i.opcode == rbpm_pkg::OP_RETURN) begin
      job_o.kind = rbpm_pkg::KIND_RETURN;
    end else if (count_sat == '0) begin
      job_o.kind = rbpm_pkg::KIND_GET_NONE;
    end else begin
      job_o.kind = rbpm_pkg::KIND_GET;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rbpm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbpm_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rbpm_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire rbpm_pkg::job_t        push_data_i,
  input  wire logic                  pop_i,
  output rbpm_pkg::job_t             head_o,
  output rbpm_pkg::queue_stat_t      stat_o
);

  localparam int Depth = rbpm_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rbpm_pkg::job_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rbpm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbpm_back
// Executes jobs against the handle ring and drives the result register.
// ----------------------------------------------------------------------------
module rbpm_back #(
  parameter int POOL_BUFFERS = rbpm_pkg::DEF_POOL_BUFFERS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rbpm_pkg::job_t        head_i,
  input  wire rbpm_pkg::queue_stat_t q_stat_i,
  output logic                       pop_o,
  output logic                       ready_o,
  output logic                       result_valid_o,
  output rbpm_pkg::result_t          result_o
);

  localparam int RingSlots = POOL_BUFFERS + 1;
  localparam int PtrW      = $clog2(RingSlots);
  localparam int HandleW   = rbpm_pkg::HANDLE_W;
  localparam int CntW      = rbpm_pkg::CNT_W;
  localparam int OutW      = rbpm_pkg::OUTST_W;
  localparam int SumW      = OutW + 1;
  localparam logic [PtrW-1:0] LastSlot  = PtrW'(RingSlots - 1);
  localparam logic [PtrW-1:0] RingWrap  = PtrW'(RingSlots);

  logic [HandleW-1:0] ring_mem [RingSlots];
  logic               full_mem [RingSlots];

  rbpm_pkg::state_e   state_q, state_d;
  logic [PtrW-1:0]    init_q, init_d;
  logic [PtrW-1:0]    front_q, front_d;
  logic [PtrW-1:0]    back_q, back_d;
  logic [OutW-1:0]    outstanding_q, outstanding_d;
  logic [rbpm_pkg::SHORT_W-1:0] shortage_q, shortage_d;
  logic [CntW-1:0]    remain_q, remain_d;
  rbpm_pkg::job_t     job_q, job_d;
  logic               res_valid_q, res_valid_d;
  rbpm_pkg::result_t  res_q, res_d;

  logic [HandleW-1:0] ring_rd_q;
  logic               full_rd_q;
  logic               ring_we, full_we, full_wd;
  logic [PtrW-1:0]    ring_wa, ring_ra, full_wa;
  logic [HandleW-1:0] ring_wd;

  logic [PtrW-1:0]    front_inc, back_inc, avail;
  logic [CntW-1:0]    grant;
  logic [SumW-1:0]    out_sum;
  logic [OutW-1:0]    out_add, out_sub;
  logic               pool_empty;

  assign front_inc  = (front_q == LastSlot) ? '0 : front_q + 1'b1;
  assign back_inc   = (back_q == LastSlot) ? '0 : back_q + 1'b1;
  assign pool_empty = (front_q == back_q);
  assign avail      = back_q - front_q + ((back_q < front_q) ? RingWrap : '0);
  assign grant      = (32'(avail) > 32'(job_q.count)) ? job_q.count : CntW'(avail);
  assign out_sum    = {1'b0, outstanding_q} + SumW'(grant);
  assign out_add    = (out_sum > {1'b0, rbpm_pkg::OUTSTANDING_MAX}) ?
                      rbpm_pkg::OUTSTANDING_MAX : out_sum[OutW-1:0];
  assign out_sub    = (outstanding_q == '0) ? '0 : outstanding_q - 1'b1;

  assign ready_o        = (state_q != rbpm_pkg::ST_INIT);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbpm_pkg::ST_INIT: begin
        if (init_q == LastSlot) state_d = rbpm_pkg::ST_IDLE;
      end
      rbpm_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) state_d = rbpm_pkg::ST_START;
      end
      rbpm_pkg::ST_START: begin
        if (job_q.kind == rbpm_pkg::KIND_GET && !pool_empty && grant > CntW'(1)) begin
          state_d = rbpm_pkg::ST_GRANT;
        end else begin
          state_d = rbpm_pkg::ST_IDLE;
        end
      end
      rbpm_pkg::ST_GRANT: begin
        if (remain_q == CntW'(1)) state_d = rbpm_pkg::ST_IDLE;
      end
      default: state_d = rbpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    init_d        = init_q;
    front_d       = front_q;
    back_d        = back_q;
    outstanding_d = outstanding_q;
    shortage_d    = shortage_q;
    remain_d      = remain_q;
    job_d         = job_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;
    pop_o         = 1'b0;
    ring_we       = 1'b0;
    ring_wa       = back_q;
    ring_wd       = job_q.handle;
    ring_ra       = front_q;
    full_we       = 1'b0;
    full_wa       = front_q;
    full_wd       = 1'b0;

    unique case (state_q)
      rbpm_pkg::ST_INIT: begin
        // clearing pass: slot i holds handle i, all but the gap occupied
        ring_we = 1'b1;
        ring_wa = init_q;
        ring_wd = HandleW'(init_q);
        full_we = 1'b1;
        full_wa = init_q;
        full_wd = (init_q != LastSlot);
        init_d  = init_q + 1'b1;
      end
      rbpm_pkg::ST_IDLE: begin
        pop_o = !q_stat_i.empty;
        job_d = head_i;
      end
      rbpm_pkg::ST_START: begin
        res_valid_d          = 1'b1;
        res_d.status         = rbpm_pkg::STATUS_OK;
        res_d.granted_handle = '0;
        res_d.handle_valid   = 1'b0;
        res_d.last           = 1'b1;
        res_d.outstanding    = outstanding_q;
        res_d.shortage_count = shortage_q;
        unique case (job_q.kind)
          rbpm_pkg::KIND_RETURN: begin
            if (back_inc == front_q) begin
              res_d.status = rbpm_pkg::STATUS_OVERFLOW;
            end else if (full_rd_q) begin
              res_d.status = rbpm_pkg::STATUS_OCCUPIED;
            end else begin
              ring_we           = 1'b1;
              full_we           = 1'b1;
              full_wa           = back_q;
              full_wd           = 1'b1;
              back_d            = back_inc;
              outstanding_d     = out_sub;
              res_d.outstanding = out_sub;
            end
          end
          rbpm_pkg::KIND_GET: begin
            if (pool_empty) begin
              shortage_d           = shortage_q + 1'b1;
              res_d.status         = rbpm_pkg::STATUS_EMPTY;
              res_d.shortage_count = shortage_q + 1'b1;
            end else begin
              res_d.granted_handle = ring_rd_q;
              res_d.handle_valid   = 1'b1;
              res_d.last           = (grant == CntW'(1));
              res_d.outstanding    = out_add;
              outstanding_d        = out_add;
              full_we              = 1'b1;
              front_d              = front_inc;
              ring_ra              = front_inc;
              remain_d             = grant - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      rbpm_pkg::ST_GRANT: begin
        res_valid_d          = 1'b1;
        res_d.status         = rbpm_pkg::STATUS_OK;
        res_d.granted_handle = ring_rd_q;
        res_d.handle_valid   = 1'b1;
        res_d.last           = (remain_q == CntW'(1));
        full_we              = 1'b1;
        front_d              = front_inc;
        ring_ra              = front_inc;
        remain_d             = remain_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rbpm_pkg::ST_INIT;
      init_q        <= '0;
      front_q       <= '0;
      back_q        <= PtrW'(POOL_BUFFERS);
      outstanding_q <= '0;
      shortage_q    <= '0;
      remain_q      <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      init_q        <= init_d;
      front_q       <= front_d;
      back_q        <= back_d;
      outstanding_q <= outstanding_d;
      shortage_q    <= shortage_d;
      remain_q      <= remain_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd_q <= ring_mem[ring_ra];
  end

  always_ff @(posedge clk_i) begin
    if (full_we) begin
      full_mem[full_wa] <= full_wd;
    end
    full_rd_q <= full_mem[back_q];
  end

  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.handle_valid |-> res_q.status == rbpm_pkg::STATUS_OK)
    else $error("granted handle with bad status");

  a_batch_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.handle_valid && !res_q.last |=>
      res_valid_q && res_q.handle_valid)
    else $error("batch broken before last");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rbpm_pkg::ST_INIT |-> !res_valid_q && !pop_o)
    else $error("activity during clearing pass");

  a_grant_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rbpm_pkg::ST_GRANT |=> $stable(outstanding_q) && $stable(shortage_q))
    else $error("counters moved inside a batch");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LastSlot && back_q <= LastSlot)
    else $error("ring pointer out of range");

endmodule
`default_nettype wire

// ----- rtl/ring_buffer_pool_manager.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_pool_manager
// Free pool of receive buffer handles kept in a gapped ring.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results leave on
// result_o with result_valid_o high for one cycle each and cannot be held off.
// The back end pops a job while idle and executes it in the next cycle. A
// return, a get of zero and a get on an empty pool give one result,
// registered from the start state of the back end. A get granted n handles
// gives n results, one handle per cycle out of the registered ring memory
// read. The back end executes one job at a time and pops the next only from
// its idle state. A two-entry job queue lets requests be taken while a batch
// is still being handed out; busy is high while it is full. After reset a
// clearing pass loads every ring slot; busy stays high during it.
// ----------------------------------------------------------------------------
module ring_buffer_pool_manager #(
  parameter int POOL_BUFFERS = rbpm_pkg::DEF_POOL_BUFFERS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire rbpm_pkg::cmd_t    cmd_i,
  output logic                   result_valid_o,
  output rbpm_pkg::result_t      result_o
);

  rbpm_pkg::job_t        push_job;
  rbpm_pkg::job_t        head_job;
  rbpm_pkg::queue_stat_t q_stat;
  logic                  push;
  logic                  pop;
  logic                  pool_ready;

  rbpm_front u_front (
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .q_stat_i     (q_stat),
    .pool_ready_i (pool_ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  rbpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .stat_o      (q_stat)
  );

  rbpm_back #(
    .POOL_BUFFERS (POOL_BUFFERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_job),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .ready_o        (pool_ready),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ----- test/ring_buffer_pool_manager_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_pool_manager_tb
// Self-checking bench for the buffer handle pool.
// ----------------------------------------------------------------------------
// A queue of pending commands feeds a falling-edge driver. A rising-edge
// monitor mirrors every accepted transaction into a local model of the
// gapped ring and compares each result strobe with the oldest predicted
// result. A directed opening covers the overflow, the zero, saturated, partial
// and empty gets, and a full drain of the pool. The random part sweeps the pool
// between empty and full with random counts and handles, under several idle
// patterns on the command side.
// ----------------------------------------------------------------------------
module ring_buffer_pool_manager_tb;

  localparam int POOL_SIZE    = rbpm_pkg::DEF_POOL_BUFFERS;
  localparam int RING_SLOTS   = POOL_SIZE + 1;
  localparam int RANDOM_ITEMS = 420;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 20;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    rbpm_pkg::cmd_t cmd;
    logic [6:0]     idle_pct;
  } pending_cmd_t;

  typedef enum int {
    GEN_DRAIN,
    GEN_FILL
  } gen_mode_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              req_start = 1'b0;
  rbpm_pkg::cmd_t    req_cmd   = '0;
  logic              req_taken = 1'b0;
  logic              dut_busy;
  logic              res_valid;
  rbpm_pkg::result_t res_data;

  pending_cmd_t      pending_cmds[$];
  pending_cmd_t      next_cmd;
  rbpm_pkg::result_t expected_results[$];
  int                mismatches  = 0;
  int                idle_cycles = 0;
  int                gen_level   = POOL_SIZE;

  logic [rbpm_pkg::HANDLE_W-1:0] pool_ring[RING_SLOTS];
  bit                            pool_full[RING_SLOTS];
  logic [8:0]                    pool_front;
  logic [8:0]                    pool_back;
  logic [rbpm_pkg::OUTST_W-1:0]  pool_outst;
  logic [rbpm_pkg::SHORT_W-1:0]  pool_short;

  ring_buffer_pool_manager #(
    .POOL_BUFFERS(POOL_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (req_start),
    .busy          (dut_busy),
    .cmd_i         (req_cmd),
    .result_valid_o(res_valid),
    .result_o      (res_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void pool_reset();
    for (int i = 0; i < RING_SLOTS; i++) begin
      pool_ring[i] = i[rbpm_pkg::HANDLE_W-1:0];
      pool_full[i] = (i < POOL_SIZE);
    end
    pool_front = '0;
    pool_back  = 9'(POOL_SIZE);
    pool_outst = '0;
    pool_short = '0;
  endfunction

  function automatic void pool_serve(rbpm_pkg::cmd_t c);
    rbpm_pkg::result_t grant[$];
    rbpm_pkg::result_t r;
    int                want;
    int                avail;
    int                pos;
    r      = '0;
    r.last = 1'b1;
    if (c.opcode == rbpm_pkg::OP_GET) begin
      want = (c.request_count > rbpm_pkg::MAX_BATCH) ? rbpm_pkg::MAX_BATCH :
             int'(c.request_count);
      if (want == 0) begin
        r.status = rbpm_pkg::STATUS_OK;
        grant.push_back(r);
      end else if (pool_front == pool_back) begin
        pool_short = pool_short + 1'b1;
        r.status   = rbpm_pkg::STATUS_EMPTY;
        grant.push_back(r);
      end else begin
        if (pool_front <= pool_back) avail = int'(pool_back) - int'(pool_front);
        else avail = RING_SLOTS - int'(pool_front) + int'(pool_back);
        if (avail < want) want = avail;
        for (int k = 0; k < want; k++) begin
          pos              = (int'(pool_front) + k) % RING_SLOTS;
          r                = '0;
          r.status         = rbpm_pkg::STATUS_OK;
          r.granted_handle = pool_ring[pos];
          r.handle_valid   = 1'b1;
          r.last           = (k == want - 1);
          pool_full[pos]   = 1'b0;
          grant.push_back(r);
        end
        pool_front = 9'((int'(pool_front) + want) % RING_SLOTS);
        if (int'(pool_outst) + want > int'(rbpm_pkg::OUTSTANDING_MAX))
          pool_outst = rbpm_pkg::OUTSTANDING_MAX;
        else pool_outst = rbpm_pkg::OUTST_W'(int'(pool_outst) + want);
      end
    end else begin
      if ((int'(pool_back) + 1) % RING_SLOTS == int'(pool_front)) begin
        r.status = rbpm_pkg::STATUS_OVERFLOW;
      end else if (pool_full[pool_back]) begin
        r.status = rbpm_pkg::STATUS_OCCUPIED;
      end else begin
        pool_ring[pool_back] = c.returned_handle;
        pool_full[pool_back] = 1'b1;
        pool_back            = 9'((int'(pool_back) + 1) % RING_SLOTS);
        if (pool_outst != '0) pool_outst = pool_outst - 1'b1;
        r.status = rbpm_pkg::STATUS_OK;
      end
      grant.push_back(r);
    end
    foreach (grant[k]) begin
      r                = grant[k];
      r.outstanding    = pool_outst;
      r.shortage_count = pool_short;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_result(rbpm_pkg::result_t got);
    rbpm_pkg::result_t exp;
    bit                bad;
    exp = '0;
    bad = 1'b1;
    if (expected_results.size() != 0) begin
      exp = expected_results.pop_front();
      bad = (got.status !== exp.status) || (got.granted_handle !== exp.granted_handle) ||
            (got.handle_valid !== exp.handle_valid) || (got.last !== exp.last) ||
            (got.outstanding !== exp.outstanding) ||
            (got.shortage_count !== exp.shortage_count);
    end
    if (bad) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch at %0t (%0d left): exp st=%0d h=%0d v=%0b l=%0b out=%0d sh=%0d",
                 $realtime, expected_results.size(), exp.status, exp.granted_handle,
                 exp.handle_valid, exp.last, exp.outstanding, exp.shortage_count);
      if (mismatches <= REPORT_MAX)
        $display("                 got st=%0d h=%0d v=%0b l=%0b out=%0d sh=%0d",
                 got.status, got.granted_handle, got.handle_valid, got.last,
                 got.outstanding, got.shortage_count);
    end
  endfunction

  // level tracking only steers the generator between draining and filling
  function automatic void queue_cmd(logic op, int cnt, int hnd, int pct);
    pending_cmd_t p;
    int           want;
    p.cmd.opcode          = op;
    p.cmd.request_count   = cnt[rbpm_pkg::CNT_W-1:0];
    p.cmd.returned_handle = hnd[rbpm_pkg::HANDLE_W-1:0];
    p.idle_pct            = pct[6:0];
    pending_cmds.push_back(p);
    want = (cnt > rbpm_pkg::MAX_BATCH) ? rbpm_pkg::MAX_BATCH : cnt;
    if (op == rbpm_pkg::OP_GET) gen_level -= (want < gen_level) ? want : gen_level;
    else if (gen_level < POOL_SIZE) gen_level++;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!req_start || req_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        req_start <= 1'b1;
        req_cmd   <= next_cmd.cmd;
      end else begin
        req_start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (res_valid) check_result(res_data);
      if (req_start && !dut_busy) pool_serve(req_cmd);
      req_taken   <= req_start && !dut_busy;
      idle_cycles <= (res_valid || (req_start && !dut_busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    gen_mode_e mode;
    int        hits;
    int        roll;
    int        pct;
    pool_reset();

    // full pool: overflow, zero get, saturated and exact batches
    queue_cmd(rbpm_pkg::OP_RETURN, 0, 8'hAA, 0);
    queue_cmd(rbpm_pkg::OP_GET, 0, 8'hFF, 0);
    queue_cmd(rbpm_pkg::OP_GET, 31, 0, 0);
    queue_cmd(rbpm_pkg::OP_GET, 17, 8'h55, 0);
    queue_cmd(rbpm_pkg::OP_RETURN, 0, 8'hFF, 0);
    queue_cmd(rbpm_pkg::OP_RETURN, 31, 8'h00, 0);
    for (int i = 0; i < 14; i++) queue_cmd(rbpm_pkg::OP_GET, (i % 2 == 0) ? 16 : 31, 0, 0);
    // partial grant, empty pool, zero get on empty pool
    queue_cmd(rbpm_pkg::OP_GET, 20, 0, 0);
    queue_cmd(rbpm_pkg::OP_GET, 1, 0, 0);
    queue_cmd(rbpm_pkg::OP_GET, 0, 0, 0);
    queue_cmd(rbpm_pkg::OP_RETURN, 0, 8'h55, 0);
    queue_cmd(rbpm_pkg::OP_GET, 3, 0, 0);
    queue_cmd(rbpm_pkg::OP_GET, 16, 0, 0);
    queue_cmd(rbpm_pkg::OP_RETURN, 0, 8'h80, 0);
    queue_cmd(rbpm_pkg::OP_RETURN, 0, 8'h01, 0);

    mode = GEN_FILL;
    hits = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / 70) % 3)
        0:       pct = 0;
        1:       pct = 87;
        default: pct = 35;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 10)
        queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 255),
                  pct);
      else if (mode == GEN_DRAIN && roll < 85)
        queue_cmd(rbpm_pkg::OP_GET, $urandom_range(0, 31), $urandom_range(0, 255), pct);
      else if (mode == GEN_FILL && roll < 18)
        queue_cmd(rbpm_pkg::OP_GET, $urandom_range(0, 2), $urandom_range(0, 255), pct);
      else
        queue_cmd(rbpm_pkg::OP_RETURN, $urandom_range(0, 31), $urandom_range(0, 255), pct);
      if ((mode == GEN_DRAIN && gen_level == 0) || (mode == GEN_FILL && gen_level == POOL_SIZE))
        hits++;
      if (hits >= 3) begin
        mode = (mode == GEN_DRAIN) ? GEN_FILL : GEN_DRAIN;
        hits = 0;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((pending_cmds.size() != 0 || req_start || expected_results.size() != 0) &&
           idle_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled with %0d commands and %0d results outstanding",
               pending_cmds.size(), expected_results.size());
      $display("== FAIL ==");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("== PASS ==");
      end else begin
        $display("mismatches %0d, results not seen %0d", mismatches, expected_results.size());
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rbpm_pkg.sv
rtl/rbpm_front.sv
rtl/rbpm_queue.sv
rtl/rbpm_back.sv
rtl/ring_buffer_pool_manager.sv
test/ring_buffer_pool_manager_tb.sv
